// ===== src/msps_pkg.sv =====
// Shared types and constants for the multi-servo pulse sequencer.
// No dependencies; imported by every module of the block.
package msps_pkg;

    localparam int CH_W       = 4;
    localparam int US_W       = 14;
    localparam int TICK_W     = 16;
    localparam int TRIM_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PULSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM          = 3'd4;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SET_WIDTH = 2'd1,
        OP_OPEN      = 2'd2,
        OP_CLOSE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOT_AFFECTED = 2'd1,
        ST_REJECTED     = 2'd2
    } t_status;

    typedef struct packed {
        logic [US_W-1:0]   min_pulse_us;
        logic [US_W-1:0]   max_pulse_us;
        logic [US_W-1:0]   default_pulse_us;
        logic [TICK_W-1:0] refresh_ticks;
        logic [TRIM_W-1:0] trim_ticks;
    } t_cfg;

    // Classified command handed from front to back
    typedef struct packed {
        t_op               op;
        logic [CH_W-1:0]   ch;
        logic              ch_ok;
        logic              width_ok;
        logic [TICK_W-1:0] width;
    } t_cmd;

endpackage

// ===== src/multi_servo_pulse_sequencer.sv =====
// Multi-servo pulse sequencer: one item in and one result out per cycle, sustained while
// the output is not stalled. Accepted items pass the queue, then the result register. The
// back end executes one queued command per clock unless the output stalls; the two-entry
// queue absorbs output stalls. Synchronous active-low reset clears counters, channel state
// and queue; channel widths are undefined until the first open loads the default.
// Depends on msps_pkg, msps_front, msps_queue, msps_back.
module multi_servo_pulse_sequencer
    import msps_pkg::*;
#(
    parameter int MAX_CHANNELS          = 12,
    parameter int TICKS_PER_MICROSECOND = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_operation,
    input  logic [CH_W-1:0]         i_channel,
    input  logic [US_W-1:0]         i_pulse_width_us,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [MAX_CHANNELS-1:0] o_servo_pins,
    output logic [1:0]              o_status,
    output logic [CH_W-1:0]         o_assigned_channel,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign push        = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pulse_us     <= US_W'(1000);
            r_cfg.max_pulse_us     <= US_W'(2000);
            r_cfg.default_pulse_us <= US_W'(1500);
            r_cfg.refresh_ticks    <= TICK_W'(40000);
            r_cfg.trim_ticks       <= TRIM_W'(4);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MIN_PULSE:     r_cfg.min_pulse_us     <= i_cfg_data[US_W-1:0];
                CFG_MAX_PULSE:     r_cfg.max_pulse_us     <= i_cfg_data[US_W-1:0];
                CFG_DEFAULT_PULSE: r_cfg.default_pulse_us <= i_cfg_data[US_W-1:0];
                CFG_REFRESH:       r_cfg.refresh_ticks    <= i_cfg_data[TICK_W-1:0];
                CFG_TRIM:          r_cfg.trim_ticks       <= i_cfg_data[TRIM_W-1:0];
                default: ;
            endcase
        end
    end

    msps_front #(
        .MAX_CHANNELS          (MAX_CHANNELS),
        .TICKS_PER_MICROSECOND (TICKS_PER_MICROSECOND)
    ) u_front (
        .i_operation      (i_operation),
        .i_channel        (i_channel),
        .i_pulse_width_us (i_pulse_width_us),
        .i_cfg            (r_cfg),
        .o_cmd            (front_cmd)
    );

    msps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    msps_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd_valid        (q_valid),
        .i_cmd              (q_cmd),
        .o_cmd_pop          (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_servo_pins       (o_servo_pins),
        .o_status           (o_status),
        .o_assigned_channel (o_assigned_channel)
    );

endmodule

// ===== src/msps_front.sv =====
// Front end: decodes an incoming item, range-checks it and scales widths to ticks.
// Depends on msps_pkg.
module msps_front
    import msps_pkg::*;
#(
    parameter int MAX_CHANNELS          = 12,
    parameter int TICKS_PER_MICROSECOND = 2
) (
    input  logic [1:0]      i_operation,
    input  logic [CH_W-1:0] i_channel,
    input  logic [US_W-1:0] i_pulse_width_us,
    input  t_cfg            i_cfg,
    output t_cmd            o_cmd
);

    localparam int TPU_W  = $clog2(TICKS_PER_MICROSECOND + 1);
    localparam int PROD_W = US_W + TPU_W;
    localparam int EXT_W  = (PROD_W > TICK_W) ? PROD_W : TICK_W;

    t_op               op;
    logic [US_W-1:0]   src_us;
    logic [PROD_W-1:0] prod;
    logic [EXT_W-1:0]  prod_ext;

    assign op       = t_op'(i_operation);
    // open carries the scaled default width for the start-up load
    assign src_us   = (op == OP_OPEN) ? i_cfg.default_pulse_us : i_pulse_width_us;
    assign prod     = PROD_W'(src_us) * PROD_W'(TICKS_PER_MICROSECOND);
    assign prod_ext = EXT_W'(prod);

    always_comb begin
        o_cmd.op       = op;
        o_cmd.ch       = i_channel;
        o_cmd.ch_ok    = {1'b0, i_channel} < (CH_W + 1)'(MAX_CHANNELS);
        o_cmd.width_ok = (i_pulse_width_us >= i_cfg.min_pulse_us) &&
                         (i_pulse_width_us <= i_cfg.max_pulse_us);
        o_cmd.width    = (prod_ext > EXT_W'(TICK_MAX)) ? TICK_MAX : prod_ext[TICK_W-1:0];
    end

endmodule

// ===== src/msps_queue.sv =====
// Two-entry command queue between front and back ends.
// Depends on msps_pkg.
module msps_queue
    import msps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (PTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/msps_back.sv =====
// Back end: channel table, tick counter and pulse sequencer; one command per cycle unless the output is stalled.
// Depends on msps_pkg.
module msps_back
    import msps_pkg::*;
#(
    parameter int MAX_CHANNELS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_cmd_valid,
    input  t_cmd                    i_cmd,
    output logic                    o_cmd_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [MAX_CHANNELS-1:0] o_servo_pins,
    output logic [1:0]              o_status,
    output logic [CH_W-1:0]         o_assigned_channel
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

    // sequencer and channel state
    logic [TICK_W-1:0]       r_counter, n_counter;
    logic [TICK_W-1:0]       r_compare, n_compare;
    logic                    r_refreshing, n_refreshing;
    logic [CH_W-1:0]         r_cur, n_cur;
    logic [MAX_CHANNELS-1:0] r_open, n_open;
    logic [CNT_W-1:0]        r_alloc, n_alloc;
    logic [CNT_W-1:0]        r_open_cnt, n_open_cnt;
    logic                    r_running, n_running;
    logic [MAX_CHANNELS-1:0] r_pins, n_pins;
    logic [TICK_W-1:0]       r_width [MAX_CHANNELS];

    logic                    r_out_valid, n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic [CH_W-1:0]         r_out_assigned, n_out_assigned;

    // width table write controls
    logic                    w_load_all;
    logic                    w_we;
    logic [IDX_W-1:0]        w_idx;

    logic                    fire;
    logic [MAX_CHANNELS-1:0] elig;
    logic                    found;
    logic [IDX_W-1:0]        next_idx;
    logic [TICK_W-1:0]       base;
    logic [TICK_W-1:0]       next_cmp;
    logic [TICK_W-1:0]       frame_cmp;
    logic [TICK_W-1:0]       cnt_inc;
    logic [IDX_W-1:0]        ch_idx;
    logic [IDX_W-1:0]        cur_idx;
    logic [IDX_W-1:0]        alloc_idx;
    logic                    close_hit;
    logic [CNT_W-1:0]        open_dec;

    assign fire      = i_cmd_valid && (!r_out_valid || !i_out_stall);
    assign o_cmd_pop = fire;

    assign ch_idx    = i_cmd.ch[IDX_W-1:0];
    assign cur_idx   = r_cur[IDX_W-1:0];
    assign alloc_idx = r_alloc[IDX_W-1:0];
    assign cnt_inc   = r_counter + TICK_W'(1);

    // next channel to pulse: after the current one while refreshing, else from slot zero
    always_comb begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            elig[i] = r_open[i] &&
                      (!r_refreshing || ((CH_W + 1)'(i) > {1'b0, r_cur}));
        end
        found    = 1'b0;
        next_idx = '0;
        for (int i = MAX_CHANNELS - 1; i >= 0; i--) begin
            if (elig[i]) begin
                found    = 1'b1;
                next_idx = IDX_W'(i);
            end
        end
    end

    // on a match the counter equals compare while refreshing, else it restarts at zero
    assign base      = r_refreshing ? r_compare : '0;
    assign next_cmp  = base + r_width[next_idx];
    assign frame_cmp = (base > i_cfg.refresh_ticks) ? TICK_W'(i_cfg.trim_ticks) :
                       i_cfg.refresh_ticks + TICK_W'(i_cfg.trim_ticks);
    assign close_hit = i_cmd.ch_ok && r_open[ch_idx];
    assign open_dec  = (r_open_cnt != '0) ? r_open_cnt - CNT_W'(1) : r_open_cnt;

    always_comb begin
        n_counter      = r_counter;
        n_compare      = r_compare;
        n_refreshing   = r_refreshing;
        n_cur          = r_cur;
        n_open         = r_open;
        n_alloc        = r_alloc;
        n_open_cnt     = r_open_cnt;
        n_running      = r_running;
        n_pins         = r_pins;
        n_out_status   = r_out_status;
        n_out_assigned = r_out_assigned;
        n_out_valid    = r_out_valid && i_out_stall;
        w_load_all     = 1'b0;
        w_we           = 1'b0;
        w_idx          = ch_idx;

        if (fire) begin
            n_out_valid    = 1'b1;
            n_out_status   = ST_OK;
            n_out_assigned = '0;
            unique case (i_cmd.op)
                OP_TICK: begin
                    if (r_running) begin
                        n_counter = cnt_inc;
                        if (cnt_inc == r_compare) begin
                            if (r_refreshing) begin
                                n_pins[cur_idx] = 1'b0;
                            end else begin
                                n_counter = '0;
                                n_cur     = '0;
                            end
                            n_refreshing = found;
                            if (found) begin
                                n_cur            = CH_W'(next_idx);
                                n_pins[next_idx] = 1'b1;
                                n_compare        = next_cmp;
                            end else begin
                                n_compare = frame_cmp;
                            end
                        end
                    end
                end
                OP_SET_WIDTH: begin
                    if (i_cmd.ch_ok && i_cmd.width_ok) begin
                        w_we = 1'b1;
                    end else begin
                        n_out_status = ST_REJECTED;
                    end
                end
                OP_OPEN: begin
                    if (r_alloc >= CNT_W'(MAX_CHANNELS)) begin
                        n_out_status = ST_REJECTED;
                    end else begin
                        if (!r_running) begin
                            n_open       = '0;
                            w_load_all   = 1'b1;
                            n_refreshing = 1'b0;
                            n_cur        = '0;
                            n_compare    = i_cfg.refresh_ticks;
                            n_counter    = '0;
                            n_pins       = '0;
                            n_running    = 1'b1;
                        end
                        n_open[alloc_idx] = 1'b1;
                        n_out_assigned    = CH_W'(r_alloc);
                        n_alloc           = r_alloc + CNT_W'(1);
                        n_open_cnt        = r_open_cnt + CNT_W'(1);
                    end
                end
                OP_CLOSE: begin
                    if (close_hit) begin
                        n_open[ch_idx] = 1'b0;
                        n_pins[ch_idx] = 1'b0;
                        n_open_cnt     = open_dec;
                        if (open_dec == '0) begin
                            n_running = 1'b0;
                        end
                    end else begin
                        n_out_status = ST_NOT_AFFECTED;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_all) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_width[i] <= i_cmd.width;
            end
        end else if (w_we) begin
            r_width[w_idx] <= i_cmd.width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter    <= '0;
            r_compare    <= '0;
            r_refreshing <= 1'b0;
            r_cur        <= '0;
            r_open       <= '0;
            r_alloc      <= '0;
            r_open_cnt   <= '0;
            r_running    <= 1'b0;
            r_pins       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_counter    <= n_counter;
            r_compare    <= n_compare;
            r_refreshing <= n_refreshing;
            r_cur        <= n_cur;
            r_open       <= n_open;
            r_alloc      <= n_alloc;
            r_open_cnt   <= n_open_cnt;
            r_running    <= n_running;
            r_pins       <= n_pins;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status   <= n_out_status;
        r_out_assigned <= n_out_assigned;
    end

    // pin state changes only when a result is loaded, so it doubles as the result field
    assign o_out_valid        = r_out_valid;
    assign o_servo_pins       = r_pins;
    assign o_status           = r_out_status;
    assign o_assigned_channel = r_out_assigned;

`ifndef SYNTHESIS
    a_pin_only_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pins & ~r_open) == '0)
        else $error("pin high on a channel that is not open");

    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_pins))
        else $error("more than one servo pulse active");

    a_open_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_cnt <= r_alloc)
        else $error("open count exceeds allocated count");

    a_stopped_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_open_cnt == '0))
        else $error("counter stopped with channels still open");

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_running) |-> (r_counter == '0 && r_pins == '0 && !r_refreshing))
        else $error("sequencer started from a dirty state");
`endif

endmodule

// ===== test/tb_multi_servo_pulse_sequencer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_servo_pulse_sequencer: directed and random items,
// with an item-level predictor of the servo sequencer kept in a small scoreboard class.
// Depends on msps_pkg and the multi_servo_pulse_sequencer RTL.

import msps_pkg::*;

localparam int SERVO_CH     = 12;
localparam int TICKS_PER_US = 2;

typedef struct packed {
    logic [SERVO_CH-1:0] pins;
    t_status             status;
    logic [CH_W-1:0]     assigned;
} t_servo_result;

class pulse_scoreboard;
    // register copies
    logic [US_W-1:0]   min_us, max_us, dflt_us;
    logic [TICK_W-1:0] refresh;
    logic [TRIM_W-1:0] trim;

    // sequencer state
    logic [TICK_W-1:0] counter, compare;
    bit                in_frame, running;
    int unsigned       cur_ch, allocated, open_cnt;
    logic [TICK_W-1:0] width_ticks [16];
    bit                ch_open [16];
    logic [15:0]       pins;

    t_servo_result     expected_q [$];
    int unsigned       errors, checked, frame_starts, pulse_starts, overdue_ends;

    function new();
        min_us   = 1000;
        max_us   = 2000;
        dflt_us  = 1500;
        refresh  = 40000;
        trim     = 4;
        counter  = '0;
        compare  = '0;
        in_frame = 1'b0;
        running  = 1'b0;
        cur_ch   = 0;
        allocated = 0;
        open_cnt = 0;
        pins     = '0;
        for (int i = 0; i < 16; i++) begin
            width_ticks[i] = '0;
            ch_open[i]     = 1'b0;
        end
        errors = 0;
        checked = 0;
        frame_starts = 0;
        pulse_starts = 0;
        overdue_ends = 0;
    endfunction

    function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MIN_PULSE:     min_us  = data[US_W-1:0];
            CFG_MAX_PULSE:     max_us  = data[US_W-1:0];
            CFG_DEFAULT_PULSE: dflt_us = data[US_W-1:0];
            CFG_REFRESH:       refresh = data[TICK_W-1:0];
            CFG_TRIM:          trim    = data[TRIM_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [TICK_W-1:0] to_ticks(logic [US_W-1:0] us);
        int unsigned t;
        t = us * TICKS_PER_US;
        return (t > TICK_MAX) ? TICK_MAX : TICK_W'(t);
    endfunction

    // Start the first open channel at or after first; otherwise close the frame.
    function void start_next(int unsigned first);
        for (int i = first; i < allocated; i++) begin
            if (ch_open[i]) begin
                cur_ch  = i;
                pins[i] = 1'b1;
                compare = counter + width_ticks[i];
                pulse_starts++;
                return;
            end
        end
        in_frame = 1'b0;
        if (counter > refresh) begin
            compare = TICK_W'(trim);
            overdue_ends++;
        end else begin
            compare = refresh + TICK_W'(trim);
        end
    endfunction

    function void on_match();
        if (in_frame) begin
            pins[cur_ch] = 1'b0;
            start_next(cur_ch + 1);
        end else begin
            counter  = '0;
            cur_ch   = 0;
            in_frame = 1'b1;
            frame_starts++;
            start_next(0);
        end
    endfunction

    function void start_all();
        for (int i = 0; i < 16; i++) begin
            ch_open[i]     = 1'b0;
            width_ticks[i] = to_ticks(dflt_us);
        end
        in_frame = 1'b0;
        cur_ch   = 0;
        compare  = refresh;
        counter  = '0;
        pins     = '0;
        running  = 1'b1;
    endfunction

    function int first_open();
        for (int i = 0; i < SERVO_CH; i++)
            if (ch_open[i]) return i;
        return 0;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function void note_input(t_op op, logic [CH_W-1:0] ch, logic [US_W-1:0] us);
        t_servo_result r;
        r.status   = ST_OK;
        r.assigned = '0;
        case (op)
            OP_TICK: begin
                if (running) begin
                    counter = counter + 1'b1;
                    if (counter == compare) on_match();
                end
            end
            OP_SET_WIDTH: begin
                if (ch < SERVO_CH && us >= min_us && us <= max_us)
                    width_ticks[ch] = to_ticks(us);
                else
                    r.status = ST_REJECTED;
            end
            OP_OPEN: begin
                if (allocated >= SERVO_CH) begin
                    r.status = ST_REJECTED;
                end else begin
                    if (!running) start_all();
                    r.assigned = CH_W'(allocated);
                    ch_open[allocated] = 1'b1;
                    allocated++;
                    open_cnt++;
                end
            end
            OP_CLOSE: begin
                if (ch < SERVO_CH && ch_open[ch]) begin
                    ch_open[ch] = 1'b0;
                    pins[ch]    = 1'b0;
                    if (open_cnt > 0) open_cnt--;
                    if (open_cnt == 0) running = 1'b0;
                end else begin
                    r.status = ST_NOT_AFFECTED;
                end
            end
        endcase
        r.pins = pins[SERVO_CH-1:0];
        expected_q.push_back(r);
    endfunction

    function void check_result(logic [SERVO_CH-1:0] pins_got, logic [1:0] status_got,
                               logic [CH_W-1:0] chan_got);
        t_servo_result want;
        if (expected_q.size() == 0) begin
            $error("result with no item pending: servo_pins %h status %0d assigned %0d",
                   pins_got, status_got, chan_got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (pins_got !== want.pins) begin
            $error("servo_pins mismatch: expected %h, actual %h", want.pins, pins_got);
            errors++;
        end
        if (status_got !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_got);
            errors++;
        end
        if (chan_got !== want.assigned) begin
            $error("assigned_channel mismatch: expected %0d, actual %0d",
                   want.assigned, chan_got);
            errors++;
        end
    endfunction
endclass

module tb_multi_servo_pulse_sequencer;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned LONG_HOLD   = 80;
    localparam int unsigned WRAP_TICKS  = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_operation;
    logic [CH_W-1:0]       i_channel;
    logic [US_W-1:0]       i_pulse_width_us;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [SERVO_CH-1:0]   o_servo_pins;
    logic [1:0]            o_status;
    logic [CH_W-1:0]       o_assigned_channel;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pulse_scoreboard sb;
    bit              calm;
    bit              long_hold_done;
    int unsigned     items_sent;
    int unsigned     cycles;

    multi_servo_pulse_sequencer #(
        .MAX_CHANNELS          (SERVO_CH),
        .TICKS_PER_MICROSECOND (TICKS_PER_US)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_channel          (i_channel),
        .i_pulse_width_us   (i_pulse_width_us),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_servo_pins       (o_servo_pins),
        .o_status           (o_status),
        .o_assigned_channel (o_assigned_channel),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("multi_servo_pulse_sequencer test failed");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold to back up the block.
    initial begin
        i_out_stall    = 1'b0;
        long_hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && sb.checked >= 120) begin
                long_hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_servo_pins, o_status, o_assigned_channel);
    end

    task automatic send_item(t_op op, logic [CH_W-1:0] ch, logic [US_W-1:0] us);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_channel        <= ch;
        i_pulse_width_us <= us;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        sb.note_input(op, ch, us);
        items_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        sb.write_cfg(idx, CFG_DATA_W'(value));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Close every open channel, tick while stopped, then open to restart the frame.
    task automatic restart_channels();
        for (int c = 0; c < SERVO_CH; c++)
            if (sb.ch_open[c]) send_item(OP_CLOSE, CH_W'(c), US_W'($urandom));
        repeat (2) send_item(OP_TICK, CH_W'($urandom), US_W'($urandom));
        send_item(OP_OPEN, CH_W'($urandom), US_W'($urandom));
    endtask

    task automatic random_item(int unsigned open_limit);
        int unsigned     r;
        int unsigned     lo;
        int unsigned     hi;
        t_op             op;
        logic [CH_W-1:0] ch;
        logic [US_W-1:0] us;
        r  = $urandom_range(0, 99);
        ch = CH_W'($urandom_range(0, 15));
        us = US_W'($urandom);
        if (r < 68) begin
            op = OP_TICK;
        end else if (r < 87) begin
            op = OP_SET_WIDTH;
            if ($urandom_range(0, 7) != 0) ch = CH_W'($urandom_range(0, SERVO_CH - 1));
            lo = (sb.min_us > 2) ? sb.min_us - 2 : 0;
            hi = (sb.max_us < 16381) ? sb.max_us + 2 : 16383;
            case ($urandom_range(0, 7))
                0:       us = sb.min_us;
                1:       us = sb.max_us;
                2, 3:    ;
                default: us = US_W'($urandom_range(hi, lo));
            endcase
        end else if (r < 92) begin
            op = (sb.allocated < open_limit) ? OP_OPEN : OP_TICK;
        end else begin
            op = OP_CLOSE;
            // keep at least one channel running
            if (ch < SERVO_CH && sb.ch_open[ch] && sb.open_cnt == 1) op = OP_TICK;
        end
        send_item(op, ch, us);
    endtask

    task automatic run_phase(int unsigned min_us, max_us, dflt_us, refresh, trim,
                             bit restart, int unsigned n_items, int unsigned open_limit);
        drain_results();
        write_reg(CFG_MIN_PULSE, min_us);
        write_reg(CFG_MAX_PULSE, max_us);
        write_reg(CFG_DEFAULT_PULSE, dflt_us);
        write_reg(CFG_REFRESH, refresh);
        write_reg(CFG_TRIM, trim);
        i_cfg_valid <= 1'b0;
        if (restart) restart_channels();
        repeat (n_items) random_item(open_limit);
    endtask

    initial begin
        int unsigned waited;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_operation      = OP_TICK;
        i_channel        = '0;
        i_pulse_width_us = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_MIN_PULSE;
        i_cfg_data       = '0;
        calm             = 1'b0;
        items_sent       = 0;
        sb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset register values, range edges, bad channels, stop and start
        send_item(OP_TICK, 4'd0, 14'd0);
        send_item(OP_SET_WIDTH, 4'd5, 14'd1500);
        send_item(OP_SET_WIDTH, 4'd0, 14'd999);
        send_item(OP_CLOSE, 4'd3, 14'd0);
        send_item(OP_OPEN, 4'd0, 14'd0);
        send_item(OP_OPEN, 4'd15, 14'h3FFF);
        send_item(OP_SET_WIDTH, 4'd0, 14'd1000);
        send_item(OP_SET_WIDTH, 4'd1, 14'd2000);
        send_item(OP_SET_WIDTH, 4'd1, 14'd2001);
        send_item(OP_SET_WIDTH, 4'd12, 14'd1500);
        send_item(OP_SET_WIDTH, 4'd15, 14'h3FFF);
        send_item(OP_SET_WIDTH, 4'd11, 14'd0);
        send_item(OP_CLOSE, 4'd15, 14'd0);
        send_item(OP_CLOSE, 4'd12, 14'd0);
        send_item(OP_TICK, 4'd0, 14'd0);
        send_item(OP_TICK, 4'd0, 14'd0);
        send_item(OP_CLOSE, 4'd1, 14'd0);
        send_item(OP_CLOSE, 4'd1, 14'd0);
        send_item(OP_TICK, 4'd0, 14'd0);
        send_item(OP_CLOSE, 4'd0, 14'd0);
        send_item(OP_TICK, 4'd0, 14'd0);
        send_item(OP_SET_WIDTH, 4'd2, 14'h2AAA);

        run_phase(1, 8, 3, 50, 3, 1'b1, 200, 5);
        run_phase(0, 16383, 16383, 65535, 255, 1'b0, 40, 0);
        run_phase(0, 0, 0, 0, 0, 1'b0, 30, 0);
        run_phase(2, 6, 4, 40, 10, 1'b1, 200, 7);

        // short refresh: frames run overdue and then idle until the counter wraps
        run_phase(0, 30, 6, 3, 0, 1'b1, 100, 9);
        send_item(OP_SET_WIDTH, CH_W'(sb.first_open()), 14'd0);
        calm = 1'b1;
        repeat (WRAP_TICKS) send_item(OP_TICK, CH_W'($urandom), US_W'($urandom));

        run_phase(1, 5, 2, 25, 1, 1'b1, 250, 11);

        // exhaust the slots, then stop the counter
        while (sb.allocated < SERVO_CH) send_item(OP_OPEN, CH_W'($urandom), US_W'($urandom));
        send_item(OP_OPEN, CH_W'($urandom), US_W'($urandom));
        repeat (3) send_item(OP_TICK, CH_W'($urandom), US_W'($urandom));
        for (int c = 0; c < SERVO_CH; c++)
            if (sb.ch_open[c]) send_item(OP_CLOSE, CH_W'(c), US_W'($urandom));
        send_item(OP_CLOSE, 4'd0, 14'd0);
        repeat (3) send_item(OP_TICK, CH_W'($urandom), US_W'($urandom));
        i_in_valid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (4) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors += sb.pending();
        end

        $display("run covered %0d items and %0d checked results over six register settings",
                 items_sent, sb.checked);
        $display("sequencer activity: %0d frames, %0d pulses, %0d overdue frame ends",
                 sb.frame_starts, sb.pulse_starts, sb.overdue_ends);
        if (sb.errors == 0) begin
            $display("multi_servo_pulse_sequencer test passed");
        end else begin
            $display("multi_servo_pulse_sequencer test failed");
        end
        $finish;
    end

endmodule
